@@ hw/rtl/wsrs_pkg.sv @@
// Shared types and constants for the weighted score record sorter.
package wsrs_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_OUT      = 16;

    localparam int ID_W    = 10;
    localparam int MARK_W  = 7;
    localparam int WGT_W   = 4;
    localparam int PROD_W  = 11;
    localparam int TENTH_W = 13;
    localparam int SCORE_W = 9;
    localparam int RANK_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam int RND_SUM_W = TENTH_W + 1;
    localparam int RND_PRD_W = 27;
    localparam int RND_SHIFT = 16;
    localparam int RND_Q_W   = RND_PRD_W - RND_SHIFT;
    localparam logic [RND_SUM_W-1:0] RND_HALF = RND_SUM_W'(5);
    localparam logic [RND_PRD_W-1:0] RND_MUL  = RND_PRD_W'(6554);
    localparam logic [SCORE_W-1:0]   SCORE_MAX = '1;

    localparam logic [WGT_W-1:0] WGT_FIRST_RST  = WGT_W'(2);
    localparam logic [WGT_W-1:0] WGT_SECOND_RST = WGT_W'(3);
    localparam logic [WGT_W-1:0] WGT_LAST_RST   = WGT_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_WGT_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WGT_SECOND = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WGT_LAST   = CFG_IDX_W'(2);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [MARK_W-1:0]  m1;
        logic [MARK_W-1:0]  m2;
        logic [MARK_W-1:0]  m3;
        logic [TENTH_W-1:0] tenths;
    } t_rec;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_rd;
        logic round;
        logic advance;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last_addr;
        logic last_out;
    } t_sts;

endpackage

@@ hw/rtl/weighted_score_record_sorter_top.sv @@
// Top level of the weighted score record sorter.
//
//  channel | direction | handshake               | word
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid/o_in_ready   | record id, three marks, load_done
//  out     | out       | o_out_valid/i_out_ready | record, rounded score, rank, flags
//
// A record without load_done is taken while idle; records load back to back.
// After a load_done word holding n stored records, each of the min(n,16) results
// is found by one store read per record for the selection scan, then a compare,
// a rounding and an output step; the single store read port sets this.
// Reset is synchronous; no clearing pass is needed. A stalled output word holds,
// and no input word is taken until the last result of the set has gone.
module weighted_score_record_sorter_top import wsrs_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WGT_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ID_W-1:0]      i_record_id,
    input  logic [MARK_W-1:0]    i_mark_first,
    input  logic [MARK_W-1:0]    i_mark_second,
    input  logic [MARK_W-1:0]    i_mark_end,
    input  logic                 i_load_done,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ID_W-1:0]      o_out_id,
    output logic [MARK_W-1:0]    o_out_first,
    output logic [MARK_W-1:0]    o_out_second,
    output logic [MARK_W-1:0]    o_out_end,
    output logic [SCORE_W-1:0]   o_score_rounded,
    output logic [RANK_W-1:0]    o_rank,
    output logic                 o_run_end,
    output logic                 o_dropped_flag
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    wsrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_load_done (i_load_done),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    wsrs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_record_id     (i_record_id),
        .i_mark_first    (i_mark_first),
        .i_mark_second   (i_mark_second),
        .i_mark_end      (i_mark_end),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_id        (o_out_id),
        .o_out_first     (o_out_first),
        .o_out_second    (o_out_second),
        .o_out_end       (o_out_end),
        .o_score_rounded (o_score_rounded),
        .o_rank          (o_rank),
        .o_run_end       (o_run_end),
        .o_dropped_flag  (o_dropped_flag)
    );

endmodule

@@ hw/rtl/wsrs_ctrl.sv @@
// Sequencing state machine for the record sorter.
module wsrs_ctrl import wsrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_load_done,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CMP   = 5'b00100,
        S_ROUND = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_load_done) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last_out) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.advance   = 1'b1;
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/wsrs_dp.sv @@
// Datapath: weights, record store, selection scan and output word.
module wsrs_dp import wsrs_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WGT_W-1:0]     i_cfg_data,
    input  logic [ID_W-1:0]      i_record_id,
    input  logic [MARK_W-1:0]    i_mark_first,
    input  logic [MARK_W-1:0]    i_mark_second,
    input  logic [MARK_W-1:0]    i_mark_end,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic [ID_W-1:0]      o_out_id,
    output logic [MARK_W-1:0]    o_out_first,
    output logic [MARK_W-1:0]    o_out_second,
    output logic [MARK_W-1:0]    o_out_end,
    output logic [SCORE_W-1:0]   o_score_rounded,
    output logic [RANK_W-1:0]    o_rank,
    output logic                 o_run_end,
    output logic                 o_dropped_flag
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(MAX_OUT);
    localparam int EW = (CW > KW + 1) ? CW : KW + 1;

    t_rec r_mem [CAPACITY];

    logic [WGT_W-1:0] r_w1;
    logic [WGT_W-1:0] r_w2;
    logic [WGT_W-1:0] r_w3;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic [AW-1:0]    r_addr;
    logic [KW-1:0]    r_k;
    logic             r_rd_vld;
    logic             r_best_vld;
    t_rec             r_rd_data;
    logic [AW-1:0]    r_rd_idx;
    t_rec             r_best;
    logic [AW-1:0]    r_best_idx;
    logic [TENTH_W-1:0] r_prev_score;
    logic [AW-1:0]    r_prev_idx;

    logic [PROD_W-1:0]    p1;
    logic [PROD_W-1:0]    p2;
    logic [PROD_W-1:0]    p3;
    t_rec                 new_rec;
    logic                 full;
    logic [EW-1:0]        emit_cnt;
    logic                 eligible;
    logic                 better;
    logic [RND_SUM_W-1:0] rnd_sum;
    logic [RND_PRD_W-1:0] rnd_prd;
    logic [RND_Q_W-1:0]   rnd_q;

    assign p1 = PROD_W'(r_w1) * PROD_W'(i_mark_first);
    assign p2 = PROD_W'(r_w2) * PROD_W'(i_mark_second);
    assign p3 = PROD_W'(r_w3) * PROD_W'(i_mark_end);

    always_comb begin
        new_rec.id     = i_record_id;
        new_rec.m1     = i_mark_first;
        new_rec.m2     = i_mark_second;
        new_rec.m3     = i_mark_end;
        new_rec.tenths = TENTH_W'(p1) + TENTH_W'(p2) + TENTH_W'(p3);
    end

    assign full     = (r_count >= CW'(CAPACITY));
    assign emit_cnt = (EW'(r_count) < EW'(MAX_OUT)) ? EW'(r_count) : EW'(MAX_OUT);

    assign o_sts.last_addr = (CW'(r_addr) == r_count - CW'(1));
    assign o_sts.last_out  = (EW'(r_k) + EW'(1) == emit_cnt);

    assign eligible = (r_k == '0)
                   || (r_rd_data.tenths < r_prev_score)
                   || ((r_rd_data.tenths == r_prev_score) && (r_rd_idx > r_prev_idx));
    assign better   = !r_best_vld || (r_rd_data.tenths > r_best.tenths);

    assign rnd_sum = RND_SUM_W'(r_best.tenths) + RND_HALF;
    assign rnd_prd = RND_PRD_W'(rnd_sum) * RND_MUL;
    assign rnd_q   = rnd_prd[RND_PRD_W-1:RND_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_mem[r_count[AW-1:0]] <= new_rec;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1       <= WGT_FIRST_RST;
            r_w2       <= WGT_SECOND_RST;
            r_w3       <= WGT_LAST_RST;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_addr     <= '0;
            r_k        <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WGT_FIRST:  r_w1 <= i_cfg_data;
                    CFG_WGT_SECOND: r_w2 <= i_cfg_data;
                    CFG_WGT_LAST:   r_w3 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.scan_init) begin
                r_addr     <= '0;
                r_best_vld <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_addr <= r_addr + AW'(1);
                end
                if (r_rd_vld && eligible && better) begin
                    r_best_vld <= 1'b1;
                end
            end
            if (i_cmd.advance) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_k     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_idx <= r_addr;
        end
        if (r_rd_vld && eligible && better) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.advance) begin
            r_prev_score <= r_best.tenths;
            r_prev_idx   <= r_best_idx;
        end
        if (i_cmd.round) begin
            o_out_id        <= r_best.id;
            o_out_first     <= r_best.m1;
            o_out_second    <= r_best.m2;
            o_out_end       <= r_best.m3;
            o_score_rounded <= (rnd_q > RND_Q_W'(SCORE_MAX)) ? SCORE_MAX : rnd_q[SCORE_W-1:0];
            o_rank          <= RANK_W'(r_k);
            o_run_end       <= o_sts.last_out;
            o_dropped_flag  <= r_ovf;
        end
    end

endmodule

@@ tb/weighted_score_record_sorter_top_tb.sv @@
// Self-checking testbench for the weighted score record sorter.
module weighted_score_record_sorter_top_tb;
    import wsrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned ITEMS_PER_REGIME = 140;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [MARK_W-1:0]  m1;
        logic [MARK_W-1:0]  m2;
        logic [MARK_W-1:0]  m3;
        logic [SCORE_W-1:0] score;
        logic [RANK_W-1:0]  rank;
        logic               run_end;
        logic               dropped;
    } t_graded;

    class rank_board;
        t_rec             held[CAPACITY_DEF];
        int unsigned      held_count;
        bit               overflow;
        logic [WGT_W-1:0] wgt_first;
        logic [WGT_W-1:0] wgt_second;
        logic [WGT_W-1:0] wgt_last;
        t_graded          ranked_due[$];
        int unsigned      mismatches;

        function new();
            held_count = 0;
            overflow   = 1'b0;
            wgt_first  = WGT_FIRST_RST;
            wgt_second = WGT_SECOND_RST;
            wgt_last   = WGT_LAST_RST;
            mismatches = 0;
        endfunction

        function void set_weight(logic [CFG_IDX_W-1:0] idx, logic [WGT_W-1:0] val);
            case (idx)
                CFG_WGT_FIRST:  wgt_first = val;
                CFG_WGT_SECOND: wgt_second = val;
                CFG_WGT_LAST:   wgt_last = val;
                default: ;
            endcase
        endfunction

        function void note_record(logic [ID_W-1:0] id, logic [MARK_W-1:0] m1,
                                  logic [MARK_W-1:0] m2, logic [MARK_W-1:0] m3, logic done);
            t_rec    key;
            t_graded res;
            int      i;
            int      j;
            int      score;
            if (held_count < CAPACITY_DEF) begin
                key.id     = id;
                key.m1     = m1;
                key.m2     = m2;
                key.m3     = m3;
                key.tenths = TENTH_W'(int'(wgt_first) * int'(m1) + int'(wgt_second) * int'(m2)
                                      + int'(wgt_last) * int'(m3));
                held[held_count] = key;
                held_count++;
            end else begin
                overflow = 1'b1;
            end
            if (!done) return;
            for (i = 1; i < int'(held_count); i++) begin
                key = held[i];
                j = i;
                while (j > 0 && held[j-1].tenths < key.tenths) begin
                    held[j] = held[j-1];
                    j--;
                end
                held[j] = key;
            end
            for (i = 0; i < int'(held_count); i++) begin
                score = (int'(held[i].tenths) + 5) / 10;
                if (score > int'(SCORE_MAX)) score = int'(SCORE_MAX);
                res.id      = held[i].id;
                res.m1      = held[i].m1;
                res.m2      = held[i].m2;
                res.m3      = held[i].m3;
                res.score   = SCORE_W'(score);
                res.rank    = RANK_W'(i);
                res.run_end = (i == int'(held_count) - 1);
                res.dropped = overflow;
                ranked_due.push_back(res);
            end
            held_count = 0;
            overflow   = 1'b0;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_result(t_graded got);
            t_graded want;
            if (ranked_due.size() == 0) begin
                report_mismatch("unexpected result, out_id", int'(got.id), 0);
                return;
            end
            want = ranked_due.pop_front();
            if (got.id !== want.id)
                report_mismatch("out_id", int'(got.id), int'(want.id));
            if (got.m1 !== want.m1)
                report_mismatch("out_first", int'(got.m1), int'(want.m1));
            if (got.m2 !== want.m2)
                report_mismatch("out_second", int'(got.m2), int'(want.m2));
            if (got.m3 !== want.m3)
                report_mismatch("out_end", int'(got.m3), int'(want.m3));
            if (got.score !== want.score)
                report_mismatch("score_rounded", int'(got.score), int'(want.score));
            if (got.rank !== want.rank)
                report_mismatch("rank", int'(got.rank), int'(want.rank));
            if (got.run_end !== want.run_end)
                report_mismatch("run_end", int'(got.run_end), int'(want.run_end));
            if (got.dropped !== want.dropped)
                report_mismatch("dropped_flag", int'(got.dropped), int'(want.dropped));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WGT_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [ID_W-1:0]      i_record_id = '0;
    logic [MARK_W-1:0]    i_mark_first = '0;
    logic [MARK_W-1:0]    i_mark_second = '0;
    logic [MARK_W-1:0]    i_mark_end = '0;
    logic                 i_load_done = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ID_W-1:0]      o_out_id;
    logic [MARK_W-1:0]    o_out_first;
    logic [MARK_W-1:0]    o_out_second;
    logic [MARK_W-1:0]    o_out_end;
    logic [SCORE_W-1:0]   o_score_rounded;
    logic [RANK_W-1:0]    o_rank;
    logic                 o_run_end;
    logic                 o_dropped_flag;

    rank_board   board;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned out_hold_req = 0;
    int unsigned records_sent = 0;

    weighted_score_record_sorter_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_record_id     (i_record_id),
        .i_mark_first    (i_mark_first),
        .i_mark_second   (i_mark_second),
        .i_mark_end      (i_mark_end),
        .i_load_done     (i_load_done),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_id        (o_out_id),
        .o_out_first     (o_out_first),
        .o_out_second    (o_out_second),
        .o_out_end       (o_out_end),
        .o_score_rounded (o_score_rounded),
        .o_rank          (o_rank),
        .o_run_end       (o_run_end),
        .o_dropped_flag  (o_dropped_flag)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic push_record(logic [ID_W-1:0] id, logic [MARK_W-1:0] m1,
                               logic [MARK_W-1:0] m2, logic [MARK_W-1:0] m3, logic done);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_record_id   <= id;
        i_mark_first  <= m1;
        i_mark_second <= m2;
        i_mark_end    <= m3;
        i_load_done   <= done;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_record(id, m1, m2, m3, done);
    endtask

    task automatic settle(int unsigned tail);
        i_in_valid <= 1'b0;
        while (board.ranked_due.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_weight(logic [CFG_IDX_W-1:0] idx, logic [WGT_W-1:0] val);
        settle(8);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_weight(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_set(int unsigned len);
        int unsigned top;
        int unsigned i;
        top = ($urandom_range(3) == 0) ? 3 : (($urandom_range(2) == 0) ? 127 : 100);
        for (i = 0; i < len; i++)
            push_record(ID_W'($urandom_range(1023)), MARK_W'($urandom_range(top)),
                        MARK_W'($urandom_range(top)), MARK_W'($urandom_range(top)), i == len - 1);
        records_sent += len;
    endtask

    function automatic logic [WGT_W-1:0] pick_weight();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return WGT_W'(10);
            default: return WGT_W'($urandom_range(15));
        endcase
    endfunction

    initial begin : result_sink
        t_graded     got;
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.id      = o_out_id;
                got.m1      = o_out_first;
                got.m2      = o_out_second;
                got.m3      = o_out_end;
                got.score   = o_score_rounded;
                got.rank    = o_rank;
                got.run_end = o_run_end;
                got.dropped = o_dropped_flag;
                board.check_result(got);
            end
            if (out_hold_req > 0) begin
                hold_left = out_hold_req;
                out_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned sets;
        int unsigned len;
        int          i;
        board = new();
        sets  = 0;
        send_idle = 15;
        recv_idle = 88;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_record(ID_W'(0), MARK_W'(0), MARK_W'(0), MARK_W'(0), 1'b0);
        push_record(ID_W'(1023), MARK_W'(100), MARK_W'(100), MARK_W'(100), 1'b0);
        push_record(ID_W'(341), MARK_W'(50), MARK_W'(50), MARK_W'(50), 1'b0);
        push_record(ID_W'(682), MARK_W'(50), MARK_W'(50), MARK_W'(50), 1'b0);
        push_record(ID_W'(240), MARK_W'(0), MARK_W'(0), MARK_W'(1), 1'b0);
        push_record(ID_W'(241), MARK_W'(1), MARK_W'(2), MARK_W'(3), 1'b1);
        push_record(ID_W'(1), MARK_W'(127), MARK_W'(127), MARK_W'(127), 1'b1);

        write_weight(CFG_WGT_FIRST, '1);
        write_weight(CFG_WGT_SECOND, '1);
        write_weight(CFG_WGT_LAST, '1);
        push_record(ID_W'(1023), MARK_W'(127), MARK_W'(127), MARK_W'(127), 1'b0);
        write_weight(CFG_SPARE, WGT_W'(10));
        write_weight(CFG_WGT_FIRST, '0);
        push_record(ID_W'(512), MARK_W'(127), MARK_W'(1), MARK_W'(0), 1'b1);

        // one word more than the store holds; the load_done word is the dropped one
        for (i = 0; i < 17; i++)
            push_record(ID_W'(16 + i), MARK_W'(i * 7), MARK_W'((i % 5) * 25),
                        MARK_W'((i % 3) * 40), i == 16);

        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    send_idle = 15;
                    recv_idle = 88;
                end
                1: begin
                    send_idle = 88;
                    recv_idle = 15;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                    settle(8);
                    // hold the receiver off so a full set backs up into the input
                    out_hold_req = HOLD_CYCLES;
                    send_set(CAPACITY_DEF);
                    send_set(12);
                    settle(8);
                end
            endcase
            while (records_sent < ITEMS_PER_REGIME * (regime + 1)) begin
                if (sets % 4 == 0) begin
                    write_weight(CFG_WGT_FIRST, pick_weight());
                    write_weight(CFG_WGT_SECOND, pick_weight());
                    write_weight(CFG_WGT_LAST, pick_weight());
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
                send_set(len);
                sets++;
            end
        end

        settle(40);
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/wsrs_pkg.sv
hw/rtl/wsrs_ctrl.sv
hw/rtl/wsrs_dp.sv
hw/rtl/weighted_score_record_sorter_top.sv
tb/weighted_score_record_sorter_top_tb.sv
